[design/vafa_pkg.sv]
// Package for the vision angle frame averager.
// Frame tags, result kinds, register indexes, field widths and shared types.
// No dependencies.
package vafa_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] ANGLE_TAG  = 8'hEE;
    localparam logic [7:0] ANGLE_END  = 8'hBB;
    localparam logic [7:0] SHAPE_TAG  = 8'hFF;

    localparam int BYTE_W   = 8;
    localparam int MEAN_W   = 16;
    localparam int SCALED_W = 24;
    localparam int SHAPE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int DB_W     = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Q15 gain to Q8 output
    localparam int GAIN_SHIFT = 7;

    localparam int SCALED_MAX = 8388607;
    localparam int SCALED_MIN = -8388608;

    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_SHAPE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'b1;

    localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd10;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd26214;

    // Decode event from the framer
    typedef struct packed {
        logic done;
        logic kind;
    } t_frame_ev;

endpackage

[design/vafa_framer.sv]
// Byte framer and sample accumulator for the vision angle frame averager.
// Tracks frame position, keeps header bytes 1..4, sums angle samples.
// Depends on vafa_pkg.
module vafa_framer #(
    parameter int FRAME_LEN        = 8,
    parameter int SAMPLES_PER_MEAN = 8,
    parameter int SUM_W            = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [vafa_pkg::BYTE_W-1:0]   i_byte,
    output vafa_pkg::t_frame_ev           o_ev,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic [vafa_pkg::SHAPE_W-1:0]  o_shape
);
    import vafa_pkg::*;

    localparam int CNT_W  = $clog2(FRAME_LEN);
    localparam int SCNT_W = (SAMPLES_PER_MEAN > 1) ? $clog2(SAMPLES_PER_MEAN) : 1;

    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;
    logic [SCNT_W-1:0]       r_scnt;
    logic [SCNT_W-1:0]       n_scnt;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [BYTE_W-1:0]       r_hdr [4];
    logic [BYTE_W-1:0]       hdr_cur [4];
    logic                    frame_end;
    logic                    is_angle;
    logic                    is_shape;
    logic                    mean_done;
    logic signed [SUM_W-1:0] sum_add;
    logic [SHAPE_W-1:0]      word;

    // header bytes 1..4; the closing byte may itself be byte 4
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hdr_cur[k] = (r_cnt == CNT_W'(k + 1)) ? i_byte : r_hdr[k];
        end
    end

    assign word      = {hdr_cur[2], hdr_cur[1]};
    assign frame_end = (r_cnt == CNT_W'(FRAME_LEN - 1));
    assign is_angle  = (hdr_cur[0] == ANGLE_TAG) && (hdr_cur[3] == ANGLE_END);
    assign is_shape  = (hdr_cur[0] == SHAPE_TAG);
    assign sum_add   = r_sum + SUM_W'($signed(word));
    assign mean_done = (r_scnt == SCNT_W'(SAMPLES_PER_MEAN - 1));

    always_comb begin
        n_cnt     = r_cnt;
        n_scnt    = r_scnt;
        n_sum     = r_sum;
        o_ev.done = 1'b0;
        o_ev.kind = KIND_ANGLE;
        o_sum     = '0;
        o_shape   = '0;
        priority if (r_cnt == '0 && i_byte != START_BYTE) begin
            n_cnt = '0;
        end else if (frame_end) begin
            n_cnt = '0;
            priority if (is_angle) begin
                if (mean_done) begin
                    o_ev.done = 1'b1;
                    o_sum     = sum_add;
                    n_sum     = '0;
                    n_scnt    = '0;
                end else begin
                    n_sum  = sum_add;
                    n_scnt = r_scnt + 1'b1;
                end
            end else if (is_shape) begin
                o_ev.done = 1'b1;
                o_ev.kind = KIND_SHAPE;
                o_shape   = word;
            end else begin
                n_cnt = '0;
            end
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_scnt <= '0;
            r_sum  <= '0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_scnt <= n_scnt;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < 4; k++) begin
                if (r_cnt == CNT_W'(k + 1)) begin
                    r_hdr[k] <= i_byte;
                end
            end
        end
    end

endmodule

[design/vision_angle_frame_averager.sv]
// Vision angle frame averager, top level.
// Framer plus the mean, deadband and gain pipeline. Depends on vafa_pkg, vafa_framer.
//
// Takes one received byte per transaction, every cycle it is sent and not stalled.
// Frames start on 0xAA and are FRAME_LEN bytes long. An angle frame (byte 1 0xEE,
// byte 4 0xBB) adds its signed little-endian sample (bytes 2, 3) to a running sum;
// every SAMPLES_PER_MEAN samples one result leaves carrying the mean (truncated
// toward zero, zeroed when its magnitude is within deadband_limit) and that mean
// times output_gain (Q1.15) in Q8, truncated toward zero and saturated to 24 bits.
// A shape frame (byte 1 0xFF) leaves its 16-bit word. Other frames give nothing.
// Throughput is one byte per cycle while input stall is low. After the transaction of
// the frame's last byte a result passes framer register, reciprocal multiply for
// the mean, deadband, gain multiply, Q8 rounding and saturation. Each stage holds
// only while the stage after it is full and stalled, so input stall rises only when
// all five result stages are occupied. Configuration writes go through a plain
// write port: index 0 deadband_limit, index 1 output_gain.
module vision_angle_frame_averager #(
    parameter int FRAME_LEN        = 8,
    parameter int SAMPLES_PER_MEAN = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [vafa_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic signed [vafa_pkg::MEAN_W-1:0]  o_mean_angle,
    output logic signed [vafa_pkg::SCALED_W-1:0] o_scaled_angle,
    output logic [vafa_pkg::SHAPE_W-1:0]        o_shape_word,
    input  logic                                i_cfg_we,
    input  logic [vafa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vafa_pkg::CFG_W-1:0]          i_cfg_data
);
    import vafa_pkg::*;

    // sum range covers SAMPLES_PER_MEAN full-scale samples
    localparam int SUM_W    = MEAN_W + 1 + $clog2(SAMPLES_PER_MEAN);
    // floor(mag * RECIP >> RECIP_SH) == mag / N for every mag below 2**SUM_W
    localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_MEAN);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SH) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W   = SUM_W + RECIP_W;
    // quotient magnitude never exceeds 32768
    localparam int Q_W      = MEAN_W + 1;
    localparam int GP_W     = MEAN_W + GAIN_W + 1;
    localparam logic signed [GP_W-1:0] SAT_HI  = GP_W'(SCALED_MAX);
    localparam logic signed [GP_W-1:0] SAT_LO  = GP_W'(SCALED_MIN);
    localparam logic [GP_W-1:0]        RND_ADD = GP_W'((1 << GAIN_SHIFT) - 1);

    // config registers
    logic [DB_W-1:0]   r_deadband;
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RST;
            r_gain     <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEADBAND: r_deadband <= i_cfg_data[DB_W-1:0];
                REG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its successor moves
    logic en1, en2, en3, en4, en_o;
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic accept;

    assign en_o = !r_out_valid || !i_out_stall;
    assign en4  = !r_v4 || en_o;
    assign en3  = !r_v3 || en4;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign accept      = i_in_valid && en1;
    assign o_out_valid = r_out_valid;

    // framing and accumulation
    t_frame_ev               ev;
    logic signed [SUM_W-1:0] fr_sum;
    logic [SHAPE_W-1:0]      fr_shape;

    vafa_framer #(
        .FRAME_LEN        (FRAME_LEN),
        .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN),
        .SUM_W            (SUM_W)
    ) u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .o_ev     (ev),
        .o_sum    (fr_sum),
        .o_shape  (fr_shape)
    );

    // pipeline payload
    logic                     r1_kind, r2_kind, r3_kind, r4_kind;
    logic [SHAPE_W-1:0]       r1_shape, r2_shape, r3_shape, r4_shape;
    logic signed [SUM_W-1:0]  r1_sum;
    logic                     r2_neg;
    logic [PROD_W-1:0]        r2_prod;
    logic signed [MEAN_W-1:0] r3_mean;
    logic signed [MEAN_W-1:0] r4_mean;
    logic signed [GP_W-1:0]   r4_prod;

    logic [SUM_W-1:0]         mag;
    logic [Q_W-1:0]           quot;
    logic [Q_W-1:0]           quot_db;
    logic [Q_W-1:0]           mean_q;
    logic signed [GP_W-1:0]   rnd;
    logic signed [GP_W-1:0]   shifted;
    logic signed [SCALED_W-1:0] scaled;

    // stage 2: magnitude times reciprocal
    assign mag = r1_sum[SUM_W-1] ? SUM_W'(-r1_sum) : SUM_W'(r1_sum);

    // stage 3: quotient, deadband, sign back
    assign quot    = r2_prod[RECIP_SH +: Q_W];
    assign quot_db = (quot <= Q_W'(r_deadband)) ? '0 : quot;
    assign mean_q  = r2_neg ? Q_W'(-quot_db) : quot_db;

    // stage 5: Q15 -> Q8 toward zero, then saturate
    assign rnd     = r4_prod + (r4_prod[GP_W-1] ? $signed(RND_ADD) : $signed(GP_W'(0)));
    assign shifted = rnd >>> GAIN_SHIFT;

    always_comb begin
        priority if (shifted > SAT_HI) begin
            scaled = SCALED_W'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            scaled = SCALED_W'(SAT_LO);
        end else begin
            scaled = shifted[SCALED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)  r_v1        <= accept && ev.done;
            if (en2)  r_v2        <= r_v1;
            if (en3)  r_v3        <= r_v2;
            if (en4)  r_v4        <= r_v3;
            if (en_o) r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind  <= ev.kind;
            r1_sum   <= fr_sum;
            r1_shape <= fr_shape;
        end
        if (en2) begin
            r2_kind  <= r1_kind;
            r2_shape <= r1_shape;
            r2_neg   <= r1_sum[SUM_W-1];
            r2_prod  <= PROD_W'(mag) * PROD_W'(RECIP);
        end
        if (en3) begin
            r3_kind  <= r2_kind;
            r3_shape <= r2_shape;
            r3_mean  <= mean_q[MEAN_W-1:0];
        end
        if (en4) begin
            r4_kind  <= r3_kind;
            r4_shape <= r3_shape;
            r4_mean  <= r3_mean;
            r4_prod  <= GP_W'(r3_mean) * $signed({1'b0, r_gain});
        end
        if (en_o) begin
            o_result_kind  <= r4_kind;
            o_shape_word   <= r4_shape;
            o_mean_angle   <= r4_mean;
            o_scaled_angle <= scaled;
        end
    end

endmodule

[design/vafa_checker.sv]
// Port-level checker for the vision angle frame averager, with its bind.
// Depends on vafa_pkg and the top level's ports.
module vafa_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic                                 o_result_kind,
    input logic signed [vafa_pkg::MEAN_W-1:0]   o_mean_angle,
    input logic signed [vafa_pkg::SCALED_W-1:0] o_scaled_angle,
    input logic [vafa_pkg::SHAPE_W-1:0]         o_shape_word
);
    import vafa_pkg::*;

    // shape results carry no angle
    a_shape_no_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_SHAPE |->
            o_mean_angle == '0 && o_scaled_angle == '0)
        else $error("shape result carries angle data");

    // angle results carry no shape word, and a zeroed mean scales to zero
    a_angle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_ANGLE |->
            o_shape_word == '0 && (o_mean_angle != '0 || o_scaled_angle == '0))
        else $error("angle result fields inconsistent");

    // scaled value never has the opposite sign of the mean
    a_scaled_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_ANGLE && o_scaled_angle != '0 |->
            o_scaled_angle[SCALED_W-1] == o_mean_angle[MEAN_W-1])
        else $error("scaled angle sign mismatch");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_mean_angle)
            && $stable(o_scaled_angle) && $stable(o_shape_word))
        else $error("stalled result changed");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind vision_angle_frame_averager vafa_checker u_vafa_checker (.*);
